// ----- hw/rtl/ile_pkg.sv -----
// Shared types, codes and sizes for the indexed list engine.
`default_nettype none
package ile_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = 8;
  localparam int CNT_W    = SLOT_W + 1;
  localparam int HANDLE_W = 32;
  localparam int OPC_W    = 3;
  localparam int KIND_W   = 3;

  // Opcodes as they arrive on the request channel.
  localparam logic [OPC_W-1:0] OPC_APPEND = 3'd0;
  localparam logic [OPC_W-1:0] OPC_REMOVE = 3'd1;
  localparam logic [OPC_W-1:0] OPC_GET    = 3'd2;
  localparam logic [OPC_W-1:0] OPC_SEARCH = 3'd3;
  localparam logic [OPC_W-1:0] OPC_CLEAR  = 3'd4;
  localparam logic [OPC_W-1:0] OPC_SIZE   = 3'd5;

  // Command kinds after classification in the front end.
  localparam logic [KIND_W-1:0] K_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] K_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] K_GET    = 3'd2;
  localparam logic [KIND_W-1:0] K_SEARCH = 3'd3;
  localparam logic [KIND_W-1:0] K_CLEAR  = 3'd4;
  localparam logic [KIND_W-1:0] K_SIZE   = 3'd5;
  localparam logic [KIND_W-1:0] K_BAD    = 3'd6;

  typedef struct packed {
    logic [OPC_W-1:0]    opcode;
    logic [SLOT_W-1:0]   position;
    logic [HANDLE_W-1:0] handle_in;
  } in_req_t;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] handle_out;
    logic [SLOT_W-1:0]   found_index;
    logic [CNT_W-1:0]    count;
  } out_rsp_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   position;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ile_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module ile_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ile_pkg::in_req_t in_req,
  output logic                  cmd_valid,
  output ile_pkg::cmd_t         cmd,
  input  wire logic             cmd_pop
);

  ile_pkg::cmd_t q_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push;
  ile_pkg::cmd_t cls;

  // Map the opcode to a command kind; unknown codes become a no-op kind.
  always_comb begin
    cls.position = in_req.position;
    cls.handle   = in_req.handle_in;
    unique case (in_req.opcode)
      ile_pkg::OPC_APPEND: cls.kind = ile_pkg::K_APPEND;
      ile_pkg::OPC_REMOVE: cls.kind = ile_pkg::K_REMOVE;
      ile_pkg::OPC_GET:    cls.kind = ile_pkg::K_GET;
      ile_pkg::OPC_SEARCH: cls.kind = ile_pkg::K_SEARCH;
      ile_pkg::OPC_CLEAR:  cls.kind = ile_pkg::K_CLEAR;
      ile_pkg::OPC_SIZE:   cls.kind = ile_pkg::K_SIZE;
      default:             cls.kind = ile_pkg::K_BAD;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  // Two-entry command queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (cmd_pop) begin
        rp_r <= !rp_r;
      end
      if (push && !cmd_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && cmd_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ile_back.sv -----
// Back end: list tables, link walker, search scan and the result register.
`default_nettype none
module ile_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire ile_pkg::cmd_t     cmd,
  output logic                   cmd_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ile_pkg::out_rsp_t      out_rsp
);

  localparam int SW = ile_pkg::SLOT_W;
  localparam int CW = ile_pkg::CNT_W;
  localparam int HW = ile_pkg::HANDLE_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AWR  = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_AT   = 3'd3;
  localparam logic [2:0] ST_SCMP = 3'd4;

  // Tables.
  logic [HW-1:0] val_mem  [ile_pkg::CAPACITY];
  logic [SW-1:0] nxt_mem  [ile_pkg::CAPACITY];
  logic [SW-1:0] prv_mem  [ile_pkg::CAPACITY];
  logic [SW-1:0] free_mem [ile_pkg::CAPACITY];
  logic [ile_pkg::CAPACITY-1:0] free_vld_r;

  logic [HW-1:0] val_q;
  logic [SW-1:0] nxt_q, prv_q, free_q;
  logic          fvld_q;

  logic [2:0]    st_r, st_nxt;
  ile_pkg::cmd_t op_r, op_nxt;
  logic [SW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          curv_r, curv_nxt;
  logic [SW-1:0] curpos_r, curpos_nxt, curslot_r, curslot_nxt;
  logic [SW-1:0] wslot_r, wslot_nxt, wpos_r, wpos_nxt, tgt_r, tgt_nxt;
  logic          wfwd_r, wfwd_nxt, wfirst_r, wfirst_nxt;
  logic [SW-1:0] j_r, j_nxt;
  logic          out_valid_r, out_valid_nxt;
  ile_pkg::out_rsp_t out_rsp_r, out_rsp_nxt;

  logic [SW-1:0] rd_slot, free_rd;
  logic          val_we, nxt_we, prv_we, free_we, clr_vld;
  logic [SW-1:0] val_wa, nxt_wa, prv_wa, free_wa;
  logic [HW-1:0] val_wd;
  logic [SW-1:0] nxt_wd, prv_wd, free_wd;

  // Walk start selection terms.
  logic [CW-1:0] idx9, tail_dist, best, d9;
  logic [SW-1:0] d8, walk_cur, new_slot;
  logic          pick_tail, cur_ok, has_prev, has_next;

  assign free_rd  = ~len_r[SW-1:0];
  assign walk_cur = wfirst_r ? wslot_r : (wfwd_r ? nxt_q : prv_q);
  assign new_slot = fvld_q ? free_q : len_r[SW-1:0];

  assign idx9      = {1'b0, cmd.position};
  assign tail_dist = len_r - CW'(1) - idx9;
  assign pick_tail = tail_dist < idx9;
  assign best      = pick_tail ? tail_dist : idx9;
  assign d8        = (curpos_r > cmd.position) ? (curpos_r - cmd.position)
                                               : (cmd.position - curpos_r);
  assign d9        = {1'b0, d8};
  assign cur_ok    = curv_r && ({1'b0, curpos_r} < len_r);

  assign has_prev = (op_r.position != '0);
  assign has_next = ({1'b0, op_r.position} + CW'(1)) < len_r;

  assign cmd_pop   = (st_r == ST_IDLE) && cmd_valid && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Control and sequencing.
  always_comb begin
    st_nxt      = st_r;
    op_nxt      = op_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    len_nxt     = len_r;
    curv_nxt    = curv_r;
    curpos_nxt  = curpos_r;
    curslot_nxt = curslot_r;
    wslot_nxt   = wslot_r;
    wpos_nxt    = wpos_r;
    wfwd_nxt    = wfwd_r;
    wfirst_nxt  = wfirst_r;
    tgt_nxt     = tgt_r;
    j_nxt       = j_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt = out_rsp_r;
    rd_slot     = head_r;
    val_we = 1'b0; val_wa = '0; val_wd = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
    free_we = 1'b0; free_wa = '0; free_wd = '0;
    clr_vld = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          op_nxt = cmd;
          // Default result: failure with the current count.
          out_rsp_nxt.ok          = 1'b0;
          out_rsp_nxt.handle_out  = '0;
          out_rsp_nxt.found_index = '0;
          out_rsp_nxt.count       = len_r;
          unique case (cmd.kind) inside
            ile_pkg::K_APPEND: begin
              if (len_r == CW'(ile_pkg::CAPACITY)) begin
                out_valid_nxt = 1'b1;
              end else begin
                st_nxt = ST_AWR;
              end
            end
            ile_pkg::K_REMOVE, ile_pkg::K_GET: begin
              if (idx9 < len_r) begin
                // Start from the nearest of head, tail and cursor.
                if (cur_ok && (d9 < best)) begin
                  wslot_nxt = curslot_r;
                  wpos_nxt  = curpos_r;
                end else if (pick_tail) begin
                  wslot_nxt = tail_r;
                  wpos_nxt  = SW'(len_r - CW'(1));
                end else begin
                  wslot_nxt = head_r;
                  wpos_nxt  = '0;
                end
                wfwd_nxt   = (cur_ok && (d9 < best)) ? (curpos_r < cmd.position)
                                                     : !pick_tail;
                wfirst_nxt = 1'b1;
                st_nxt     = ST_WALK;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ile_pkg::K_SEARCH: begin
              if (len_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_slot = head_r;
                j_nxt   = '0;
                st_nxt  = ST_SCMP;
              end
            end
            ile_pkg::K_CLEAR: begin
              clr_vld     = 1'b1;
              head_nxt    = '0;
              tail_nxt    = '0;
              len_nxt     = '0;
              curv_nxt    = 1'b0;
              curpos_nxt  = '0;
              curslot_nxt = '0;
              out_rsp_nxt.ok    = 1'b1;
              out_rsp_nxt.count = '0;
              out_valid_nxt     = 1'b1;
            end
            ile_pkg::K_SIZE: begin
              out_rsp_nxt.ok = 1'b1;
              out_valid_nxt  = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_AWR: begin
        // Free slot number is in hand; link it in at the tail.
        val_we = 1'b1; val_wa = new_slot; val_wd = op_r.handle;
        prv_we = 1'b1; prv_wa = new_slot; prv_wd = tail_r;
        if (len_r != '0) begin
          nxt_we = 1'b1; nxt_wa = tail_r; nxt_wd = new_slot;
        end else begin
          head_nxt = new_slot;
        end
        tail_nxt = new_slot;
        len_nxt  = len_r + CW'(1);
        out_rsp_nxt.ok         = 1'b1;
        out_rsp_nxt.handle_out = op_r.handle;
        out_rsp_nxt.count      = len_r + CW'(1);
        out_valid_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end

      ST_WALK: begin
        // One link per cycle toward the target index.
        rd_slot = walk_cur;
        if (wpos_r == op_r.position) begin
          tgt_nxt = walk_cur;
          st_nxt  = ST_AT;
        end else begin
          wpos_nxt   = wfwd_r ? (wpos_r + SW'(1)) : (wpos_r - SW'(1));
          wfirst_nxt = 1'b0;
        end
      end

      ST_AT: begin
        out_rsp_nxt.ok         = 1'b1;
        out_rsp_nxt.handle_out = val_q;
        out_valid_nxt = 1'b1;
        st_nxt = ST_IDLE;
        if (op_r.kind == ile_pkg::K_REMOVE) begin
          // Unlink the slot and return it to the free stack.
          if (has_prev) begin
            nxt_we = 1'b1; nxt_wa = prv_q; nxt_wd = nxt_q;
          end else begin
            head_nxt = nxt_q;
          end
          if (has_next) begin
            prv_we = 1'b1; prv_wa = nxt_q; prv_wd = prv_q;
          end else begin
            tail_nxt = prv_q;
          end
          free_we = 1'b1;
          free_wa = SW'(CW'(ile_pkg::CAPACITY) - len_r);
          free_wd = tgt_r;
          len_nxt = len_r - CW'(1);
          out_rsp_nxt.count = len_r - CW'(1);
          if (has_prev) begin
            curv_nxt    = 1'b1;
            curpos_nxt  = op_r.position - SW'(1);
            curslot_nxt = prv_q;
          end else if (has_next) begin
            curv_nxt    = 1'b1;
            curpos_nxt  = '0;
            curslot_nxt = nxt_q;
          end else begin
            curv_nxt    = 1'b0;
            curpos_nxt  = '0;
            curslot_nxt = '0;
          end
        end else begin
          curv_nxt    = 1'b1;
          curpos_nxt  = op_r.position;
          curslot_nxt = tgt_r;
        end
      end

      ST_SCMP: begin
        // Compare the entry read last cycle and fetch the next one.
        rd_slot = nxt_q;
        if (val_q == op_r.handle) begin
          out_rsp_nxt.ok          = 1'b1;
          out_rsp_nxt.found_index = j_r;
          out_valid_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end else if (({1'b0, j_r} + CW'(1)) == len_r) begin
          out_valid_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end else begin
          j_nxt = j_r + SW'(1);
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      curv_r      <= 1'b0;
      curpos_r    <= '0;
      curslot_r   <= '0;
      out_valid_r <= 1'b0;
      free_vld_r  <= '0;
    end else begin
      st_r        <= st_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      curv_r      <= curv_nxt;
      curpos_r    <= curpos_nxt;
      curslot_r   <= curslot_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_vld) begin
        free_vld_r <= '0;
      end else if (free_we) begin
        free_vld_r[free_wa] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    wslot_r   <= wslot_nxt;
    wpos_r    <= wpos_nxt;
    wfwd_r    <= wfwd_nxt;
    wfirst_r  <= wfirst_nxt;
    tgt_r     <= tgt_nxt;
    j_r       <= j_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // Table ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    val_q  <= val_mem[rd_slot];
    nxt_q  <= nxt_mem[rd_slot];
    prv_q  <= prv_mem[rd_slot];
    free_q <= free_mem[free_rd];
    fvld_q <= free_vld_r[free_rd];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/indexed_list_engine.sv -----
// Top level of the indexed list engine: front end queue plus back end.
// Usage:
// A request (opcode, position, handle_in) is taken on in_valid with in_stall
// low; each request yields exactly one result on out_valid/out_rsp, taken
// when out_stall is low. Results come back in request order.
// Work from the back end taking a request to its result being registered:
// size, clear, bad opcode, range or full failures: answered from idle.
// append: free-stack read, then link-in.
// get and remove: a walk of links, at most half the count, starting from
// the nearest of head, tail and cached cursor, then the update at the target.
// search: a scan from the head up to the match, or over the whole list on a miss.
// The link walk and search scan read one table entry per cycle, which sets
// the rate; a new request starts once the previous result has been taken.
// A two-entry queue in front takes up to two requests while the back end
// works or a result waits under out_stall. A stalled result holds steady.
// Reset empties the list, the queue and the result register; no table
// clearing pass is needed.
`default_nettype none
module indexed_list_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ile_pkg::in_req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ile_pkg::out_rsp_t      out_rsp
);

  logic          cmd_valid, cmd_pop;
  ile_pkg::cmd_t cmd;

  ile_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ile_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/ile_checker.sv -----
// Port-level checks for the indexed list engine and their binding.
`default_nettype none
module ile_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire ile_pkg::out_rsp_t out_rsp
);

  // A result under stall holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The count never exceeds the capacity.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.count <= ile_pkg::CNT_W'(ile_pkg::CAPACITY))
    else $error("count above capacity");

  // A failed request returns a zero handle and index.
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.ok |-> out_rsp.handle_out == '0 && out_rsp.found_index == '0)
    else $error("failed request carries data");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);
`default_nettype wire

// ----- dv/tb_indexed_list_engine.sv -----
// Self-checking testbench for the indexed list engine: directed table, then random traffic.
`timescale 1ns / 1ps
`default_nettype none
module tb_indexed_list_engine;

  localparam logic [ile_pkg::OPC_W-1:0] OPC_BAD6 = 3'd6;
  localparam logic [ile_pkg::OPC_W-1:0] OPC_BAD7 = 3'd7;

  // One directed row: request plus an optional typed-in expectation.
  typedef struct {
    ile_pkg::in_req_t  req;
    bit                typed;
    ile_pkg::out_rsp_t rsp;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  ile_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  ile_pkg::out_rsp_t out_rsp;

  // Shadow list: handles in index order; slots and links do not affect results.
  logic [ile_pkg::HANDLE_W-1:0] shadow_list[$];
  ile_pkg::out_rsp_t            pending_rsp[$];
  int unsigned                  error_total = 0;
  int unsigned                  rsp_total = 0;
  int unsigned                  op_seen[8];
  row_t                         plan[$];

  indexed_list_engine u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the result of one request and update the shadow list.
  function automatic ile_pkg::out_rsp_t list_apply(ile_pkg::in_req_t r);
    ile_pkg::out_rsp_t o;
    o = '0;
    case (r.opcode) inside
      ile_pkg::OPC_APPEND: begin
        if (shadow_list.size() < ile_pkg::CAPACITY) begin
          shadow_list.push_back(r.handle_in);
          o.ok = 1'b1;
          o.handle_out = r.handle_in;
        end
      end
      ile_pkg::OPC_REMOVE, ile_pkg::OPC_GET: begin
        if (r.position < shadow_list.size()) begin
          o.ok = 1'b1;
          o.handle_out = shadow_list[r.position];
          if (r.opcode == ile_pkg::OPC_REMOVE) shadow_list.delete(r.position);
        end
      end
      ile_pkg::OPC_SEARCH: begin
        for (int j = 0; j < shadow_list.size(); j++) begin
          if (shadow_list[j] == r.handle_in) begin
            o.ok = 1'b1;
            o.found_index = j[ile_pkg::SLOT_W-1:0];
            break;
          end
        end
      end
      ile_pkg::OPC_CLEAR: begin
        shadow_list.delete();
        o.ok = 1'b1;
      end
      ile_pkg::OPC_SIZE: o.ok = 1'b1;
      default: o.ok = 1'b0;
    endcase
    o.count = ile_pkg::CNT_W'(shadow_list.size());
    return o;
  endfunction

  // Random gap length: mostly zero or short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one request and hold it until it is taken.
  task automatic send_request(ile_pkg::in_req_t r, bit typed, ile_pkg::out_rsp_t want);
    ile_pkg::out_rsp_t pred;
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = list_apply(r);
    if (typed && pred != want) begin
      $error("typed expectation disagrees with prediction for opcode %0d", r.opcode);
      error_total++;
    end
    pending_rsp.push_back(typed ? want : pred);
    op_seen[r.opcode]++;
  endtask

  // Stop sending and wait until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  function automatic ile_pkg::in_req_t mk(logic [ile_pkg::OPC_W-1:0] op, int pos,
                                          logic [ile_pkg::HANDLE_W-1:0] h);
    ile_pkg::in_req_t r;
    r.opcode = op;
    r.position = pos[ile_pkg::SLOT_W-1:0];
    r.handle_in = h;
    return r;
  endfunction

  function automatic ile_pkg::out_rsp_t rs(bit ok, logic [ile_pkg::HANDLE_W-1:0] h, int fi,
                                           int cnt);
    ile_pkg::out_rsp_t o;
    o.ok = ok;
    o.handle_out = h;
    o.found_index = fi[ile_pkg::SLOT_W-1:0];
    o.count = cnt[ile_pkg::CNT_W-1:0];
    return o;
  endfunction

  function automatic void add(ile_pkg::in_req_t r, bit typed = 0,
                              ile_pkg::out_rsp_t o = '0);
    row_t w;
    w.req = r;
    w.typed = typed;
    w.rsp = o;
    plan.push_back(w);
  endfunction

  // Pick a random request, mostly valid indexes and handles already present.
  function automatic ile_pkg::in_req_t rand_request();
    ile_pkg::in_req_t r;
    int p, n;
    n = shadow_list.size();
    r.handle_in = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 15);
    r.position = ile_pkg::SLOT_W'($urandom_range(0, 255));
    p = $urandom_range(0, 99);
    if (p < 40) r.opcode = ile_pkg::OPC_APPEND;
    else if (p < 55) r.opcode = ile_pkg::OPC_REMOVE;
    else if (p < 75) r.opcode = ile_pkg::OPC_GET;
    else if (p < 90) r.opcode = ile_pkg::OPC_SEARCH;
    else if (p < 93) r.opcode = ile_pkg::OPC_SIZE;
    else if (p < 95) r.opcode = ile_pkg::OPC_CLEAR;
    else r.opcode = $urandom_range(0, 1) ? OPC_BAD6 : OPC_BAD7;
    if ((r.opcode == ile_pkg::OPC_REMOVE || r.opcode == ile_pkg::OPC_GET) && n > 0 &&
        $urandom_range(0, 9) < 8)
      r.position = ile_pkg::SLOT_W'($urandom_range(0, n - 1));
    if (r.opcode == ile_pkg::OPC_SEARCH && n > 0 && $urandom_range(0, 9) < 7)
      r.handle_in = shadow_list[$urandom_range(0, n - 1)];
    return r;
  endfunction

  // Receiver: random stall runs, compare each taken result with the oldest prediction.
  initial begin
    int stall_left;
    ile_pkg::out_rsp_t want;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        rsp_total++;
        if (pending_rsp.size() == 0) begin
          $error("result arrived with no request outstanding");
          error_total++;
        end else begin
          want = pending_rsp.pop_front();
          if (out_rsp.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, out_rsp.ok);
            error_total++;
          end
          if (out_rsp.handle_out !== want.handle_out) begin
            $error("handle_out: expected %0h, actual %0h", want.handle_out, out_rsp.handle_out);
            error_total++;
          end
          if (out_rsp.found_index !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index,
                   out_rsp.found_index);
            error_total++;
          end
          if (out_rsp.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_rsp.count);
            error_total++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = gap_len();
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Stimulus: directed table, then a fill-to-full burst, then random traffic.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add(mk(ile_pkg::OPC_SIZE, 0, 0), 1, rs(1, 0, 0, 0));
    add(mk(ile_pkg::OPC_GET, 0, 0), 1, rs(0, 0, 0, 0));
    add(mk(ile_pkg::OPC_REMOVE, 255, 0), 1, rs(0, 0, 0, 0));
    add(mk(ile_pkg::OPC_SEARCH, 0, 0), 1, rs(0, 0, 0, 0));
    add(mk(ile_pkg::OPC_APPEND, 0, 32'h0), 1, rs(1, 0, 0, 1));
    add(mk(ile_pkg::OPC_APPEND, 255, 32'hFFFF_FFFF), 1, rs(1, 32'hFFFF_FFFF, 0, 2));
    add(mk(ile_pkg::OPC_APPEND, 0, 32'h5A5A_A5A5));
    add(mk(ile_pkg::OPC_GET, 0, 0), 1, rs(1, 0, 0, 3));
    add(mk(ile_pkg::OPC_GET, 2, 0));
    add(mk(ile_pkg::OPC_GET, 3, 0), 1, rs(0, 0, 0, 3));
    add(mk(ile_pkg::OPC_SEARCH, 0, 32'hFFFF_FFFF), 1, rs(1, 0, 1, 3));
    add(mk(ile_pkg::OPC_SEARCH, 0, 32'h1234_5678), 1, rs(0, 0, 0, 3));
    add(mk(OPC_BAD6, 7, 32'hAAAA_5555), 1, rs(0, 0, 0, 3));
    add(mk(OPC_BAD7, 0, 0), 1, rs(0, 0, 0, 3));
    add(mk(ile_pkg::OPC_REMOVE, 1, 0), 1, rs(1, 32'hFFFF_FFFF, 0, 2));
    add(mk(ile_pkg::OPC_REMOVE, 1, 0));
    add(mk(ile_pkg::OPC_REMOVE, 0, 0), 1, rs(1, 0, 0, 0));
    add(mk(ile_pkg::OPC_APPEND, 0, 32'h0000_0001));
    add(mk(ile_pkg::OPC_CLEAR, 0, 0), 1, rs(1, 0, 0, 0));
    add(mk(ile_pkg::OPC_SIZE, 0, 0), 1, rs(1, 0, 0, 0));
    foreach (plan[i]) send_request(plan[i].req, plan[i].typed, plan[i].rsp);

    // Hold off until every result is back.
    drain();

    // Fill to capacity, then touch the far ends and overflow once.
    for (int k = 0; k < ile_pkg::CAPACITY; k++)
      send_request(mk(ile_pkg::OPC_APPEND, 0, $urandom()), 0, '0);
    send_request(mk(ile_pkg::OPC_APPEND, 0, 32'hDEAD_BEEF), 1,
                 rs(0, 0, 0, ile_pkg::CAPACITY));
    send_request(mk(ile_pkg::OPC_GET, 255, 0), 0, '0);
    send_request(mk(ile_pkg::OPC_GET, 128, 0), 0, '0);
    send_request(mk(ile_pkg::OPC_REMOVE, 255, 0), 0, '0);
    send_request(mk(ile_pkg::OPC_REMOVE, 0, 0), 0, '0);
    send_request(mk(ile_pkg::OPC_SEARCH, 0, shadow_list[shadow_list.size() - 1]), 0, '0);
    send_request(mk(ile_pkg::OPC_CLEAR, 0, 0), 0, '0);

    for (int k = 0; k < 267; k++) send_request(rand_request(), 0, '0);

    drain();
    repeat (300) @(posedge clk);
    $display("Ran %0d requests: append %0d, remove %0d, get %0d, search %0d,",
             rsp_total, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("clear %0d, size %0d, unknown opcodes %0d, including a full list.",
             op_seen[4], op_seen[5], op_seen[6] + op_seen[7]);
    if (error_total == 0 && pending_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ----- indexed_list_engine.f -----
hw/rtl/ile_pkg.sv
hw/rtl/ile_front.sv
hw/rtl/ile_back.sv
hw/rtl/indexed_list_engine.sv
hw/rtl/ile_checker.sv
dv/tb_indexed_list_engine.sv
